### design/rla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rla_pkg
// Shared constants, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rla_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int LINE_CNT_W      = 6;
  localparam int BYTE_W          = 8;
  localparam int STATUS_W        = 3;

  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LINE_ENDED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_IGNORED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_LINE       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LINE_BYTE     = 3'd5;

  typedef struct packed {
    logic do_rx;
    logic do_noline;
    logic do_pop;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic lines_zero;
    logic fill_zero;
    logic pop_last;
  } sts_t;

endpackage

### design/rla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rla_ctrl
// Request sequencer: takes one request at a time and steps line reads.
// ----------------------------------------------------------------------------
module rla_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_operation,
  input  rla_pkg::sts_t sts,
  output rla_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_operation == rla_pkg::OP_RX) begin
            cmd.do_rx = 1'b1;
          end else if (sts.lines_zero || sts.fill_zero) begin
            cmd.do_noline = 1'b1;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.do_pop = 1'b1;
          if (sts.pop_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/rla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rla_dp
// Circular byte store, pointers, line counters and the result register.
// ----------------------------------------------------------------------------
module rla_dp #(
  parameter int STORE_DEPTH = rla_pkg::STORE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rla_pkg::cmd_t                    cmd,
  output rla_pkg::sts_t                    sts,
  input  logic [rla_pkg::BYTE_W-1:0]       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rla_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                             out_last,
  output logic [rla_pkg::STATUS_W-1:0]     out_status,
  output logic [rla_pkg::LINE_CNT_W-1:0]   out_line_count
);

  localparam int PW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(STORE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(STORE_DEPTH);

  logic [rla_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
  logic [rla_pkg::BYTE_W-1:0] rdata_r;

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          open_r, open_nxt;
  logic [rla_pkg::LINE_CNT_W-1:0] lines_r, lines_nxt;

  logic                           ov_r, ov_nxt;
  logic [rla_pkg::BYTE_W-1:0]     od_r, od_nxt;
  logic                           ol_r, ol_nxt;
  logic [rla_pkg::STATUS_W-1:0]   os_r, os_nxt;
  logic [rla_pkg::LINE_CNT_W-1:0] oc_r, oc_nxt;

  logic                       full, is_term, wr_en, pop_end;
  logic [rla_pkg::BYTE_W-1:0] wr_data;
  logic [FW-1:0]              fill_dec;

  assign full     = (fill_r == FILL_MAX);
  assign is_term  = (rx_byte == rla_pkg::CHAR_CR) || (rx_byte == rla_pkg::CHAR_LF)
                    || (rx_byte == rla_pkg::CHAR_NUL);
  assign fill_dec = fill_r - FW'(1);
  assign pop_end  = (rdata_r == rla_pkg::CHAR_NUL);

  assign sts.out_free   = !ov_r || out_ready;
  assign sts.lines_zero = (lines_r == '0);
  assign sts.fill_zero  = (fill_r == '0);
  assign sts.pop_last   = pop_end || (fill_dec == '0);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    open_nxt   = open_r;
    lines_nxt  = lines_r;
    wr_en      = 1'b0;
    wr_data    = rx_byte;
    ov_nxt     = ov_r && !out_ready;
    od_nxt     = od_r;
    ol_nxt     = ol_r;
    os_nxt     = os_r;
    oc_nxt     = oc_r;

    if (cmd.do_rx) begin
      ov_nxt = 1'b1;
      od_nxt = '0;
      ol_nxt = 1'b1;
      if (is_term) begin
        if (!open_r) begin
          os_nxt = rla_pkg::ST_EMPTY_IGNORED;
        end else if (full) begin
          os_nxt = rla_pkg::ST_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          wr_data   = rla_pkg::CHAR_NUL;
          open_nxt  = 1'b0;
          lines_nxt = lines_r + 1'b1;
          os_nxt    = rla_pkg::ST_LINE_ENDED;
        end
      end else if (full) begin
        os_nxt = rla_pkg::ST_OVERFLOW;
      end else begin
        wr_en    = 1'b1;
        open_nxt = 1'b1;
        os_nxt   = rla_pkg::ST_STORED;
      end
      if (wr_en) begin
        wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
        fill_nxt   = fill_r + FW'(1);
      end
      oc_nxt = lines_nxt;
    end else if (cmd.do_noline) begin
      ov_nxt = 1'b1;
      od_nxt = '0;
      ol_nxt = 1'b1;
      os_nxt = rla_pkg::ST_NO_LINE;
      oc_nxt = lines_r;
    end else if (cmd.do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_dec;
      if (pop_end) begin
        lines_nxt = lines_r - 1'b1;
      end
      ov_nxt = 1'b1;
      od_nxt = rdata_r;
      ol_nxt = sts.pop_last;
      os_nxt = rla_pkg::ST_LINE_BYTE;
      oc_nxt = lines_nxt;
    end
  end

  // read port follows the next read pointer: one byte per cycle while popping and the output is free
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    rdata_r <= mem[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      open_r   <= 1'b0;
      lines_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      open_r   <= open_nxt;
      lines_r  <= lines_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ol_r <= ol_nxt;
    os_r <= os_nxt;
    oc_r <= oc_nxt;
  end

  assign out_valid      = ov_r;
  assign out_data_byte  = od_r;
  assign out_last       = ol_r;
  assign out_status     = os_r;
  assign out_line_count = oc_r;

endmodule

### design/rx_line_assembler_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_line_assembler_fifo
// Line-assembling receive buffer with a circular byte store.
// ----------------------------------------------------------------------------
// A received byte (operation 0) is taken and answered with one result; CR,
// LF or NUL closes a non-empty line by storing a zero. A read request
// (operation 1) with no complete line gives one "no line" result.
// Otherwise the oldest line is popped one byte per cycle while the output is
// free, ending with its zero terminator (last set); the single registered
// read port of the byte store sets that pace. A full store drops the byte
// and reports overflow.
module rx_line_assembler_fifo #(
  parameter int STORE_DEPTH = rla_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [rla_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rla_pkg::BYTE_W-1:0]     out_data_byte,
  output logic                           out_last,
  output logic [rla_pkg::STATUS_W-1:0]   out_status,
  output logic [rla_pkg::LINE_CNT_W-1:0] out_line_count
);

  rla_pkg::cmd_t cmd;
  rla_pkg::sts_t sts;

  rla_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd)
  );

  rla_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .rx_byte        (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_line_count (out_line_count)
  );

endmodule
